/* hdl/lmd_pkg.sv */
// ----------------------------------------------------------------------------
// lmd_pkg
// Shared types and constants for the LED matrix driver chain framer.
// ----------------------------------------------------------------------------
`default_nettype none

package lmd_pkg;

  localparam int LMD_MAX_DEVICES = 8;
  localparam int LMD_HARD_LIMIT  = 8;

  localparam logic [3:0] OPC_INTENSITY = 4'd10;
  localparam logic [3:0] OPC_SCANLIMIT = 4'd11;
  localparam logic [3:0] OPC_SHUTDOWN  = 4'd12;
  localparam logic [3:0] OPC_NOOP      = 4'd0;

  typedef enum logic [2:0] {
    OP_LED        = 3'd0,
    OP_ROW        = 3'd1,
    OP_COLUMN     = 3'd2,
    OP_CLEAR      = 3'd3,
    OP_POWER      = 3'd4,
    OP_BRIGHTNESS = 3'd5,
    OP_SCAN_DIGITS = 3'd6,
    OP_RAW        = 3'd7
  } lmd_op_e;

  typedef struct packed {
    logic load;
    logic rd;
    logic calc;
    logic word_step;
    logic frame_step;
  } lmd_cmd_t;

  typedef struct packed {
    logic item_ok;
    logic word_zero;
    logic frames_done;
  } lmd_sts_t;

endpackage

`default_nettype wire

/* hdl/lmd_in_if.sv */
// ----------------------------------------------------------------------------
// lmd_in_if
// Command channel: one display command per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmd_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [3:0] device;
  logic [2:0] row;
  logic [2:0] column;
  logic [7:0] value;
  logic       flag;
  logic [3:0] raw_opcode;

  modport source (
    output valid, operation, device, row, column, value, flag, raw_opcode,
    input  ready
  );
  modport sink (
    input  valid, operation, device, row, column, value, flag, raw_opcode,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/lmd_out_if.sv */
// ----------------------------------------------------------------------------
// lmd_out_if
// Chain word channel: one 16-bit chain word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] opcode;
  logic [7:0] data;
  logic       end_of_frame;
  logic       last;

  modport source (
    output valid, opcode, data, end_of_frame, last,
    input  ready
  );
  modport sink (
    input  valid, opcode, data, end_of_frame, last,
    output ready
  );
endinterface

`default_nettype wire

/* hdl/lmd_ram.sv */
// ----------------------------------------------------------------------------
// lmd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/lmd_ctrl.sv */
// ----------------------------------------------------------------------------
// lmd_ctrl
// Sequencer: read shadow, build frame, send words; per row for column/clear.
// ----------------------------------------------------------------------------
`default_nettype none

module lmd_ctrl
  import lmd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire lmd_sts_t sts_i,
  output lmd_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CALC = 4'b0100,
    S_SEND = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_acc;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_SEND);
  assign out_acc     = out_valid_o && out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.item_ok) begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CALC;
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_SEND;
      end
      S_SEND: begin
        if (out_acc) begin
          if (!sts_i.word_zero) begin
            cmd_o.word_step = 1'b1;
          end else if (sts_i.frames_done) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.frame_step = 1'b1;
            state_d          = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/lmd_dpath.sv */
// ----------------------------------------------------------------------------
// lmd_dpath
// Datapath: command registers, row shadow, frame builder, word counter.
// ----------------------------------------------------------------------------
`default_nettype none

module lmd_dpath
  import lmd_pkg::*;
#(
  parameter int MAX_DEVICES = LMD_MAX_DEVICES
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_wr_en_i,
  input  wire logic [3:0] cfg_wr_data_i,
  input  wire logic [2:0] operation_i,
  input  wire logic [3:0] device_i,
  input  wire logic [2:0] row_i,
  input  wire logic [2:0] column_i,
  input  wire logic [7:0] value_i,
  input  wire logic       flag_i,
  input  wire logic [3:0] raw_opcode_i,
  input  wire lmd_cmd_t   cmd_i,
  output lmd_sts_t        sts_o,
  output logic      [3:0] opcode_o,
  output logic      [7:0] data_o,
  output logic            end_of_frame_o,
  output logic            last_o
);

  localparam int DEV_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int DEPTH = MAX_DEVICES * 8;
  localparam int AW    = $clog2(DEPTH);
  localparam int CAP   = (MAX_DEVICES < LMD_HARD_LIMIT) ? MAX_DEVICES : LMD_HARD_LIMIT;
  localparam logic [3:0] CAP_L = 4'(CAP);

  logic [3:0] dc_q;
  logic [3:0] chain_n;

  lmd_op_e    op_q;
  logic [3:0] dev_q;
  logic [2:0] row_q;
  logic [2:0] col_q;
  logic [7:0] val_q;
  logic       flag_q;
  logic [3:0] rop_q;
  logic [2:0] word_q;
  logic [3:0] frm_opc_q;
  logic [7:0] frm_dat_q;

  logic [DEPTH-1:0] vld_q;
  logic             rvld_q;
  logic [AW-1:0]    addr;
  logic [7:0]       rdata;
  logic [7:0]       cur;
  logic [7:0]       mask;
  logic             bit_on;
  logic [7:0]       led_byte;
  logic [3:0]       row_opc;
  logic [3:0]       frm_opc_d;
  logic [7:0]       frm_dat_d;
  logic             wr_en;
  logic [7:0]       wr_data;
  logic             multi;
  logic             item_ok;

  assign chain_n = ((dc_q == 4'd0) || (dc_q > CAP_L)) ? CAP_L : dc_q;

  always_comb begin
    item_ok = (device_i < chain_n);
    if ((lmd_op_e'(operation_i) == OP_BRIGHTNESS) && (value_i >= 8'd16)) begin
      item_ok = 1'b0;
    end
    if ((lmd_op_e'(operation_i) == OP_SCAN_DIGITS) && (value_i >= 8'd8)) begin
      item_ok = 1'b0;
    end
  end

  assign sts_o.item_ok     = item_ok;
  assign multi             = (op_q == OP_COLUMN) || (op_q == OP_CLEAR);
  assign sts_o.word_zero   = (word_q == 3'd0);
  assign sts_o.frames_done = !multi || (row_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q <= 4'd8;
    end else if (cfg_wr_en_i) begin
      dc_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= lmd_op_e'(operation_i);
      dev_q  <= device_i;
      row_q  <= ((lmd_op_e'(operation_i) == OP_COLUMN) ||
                 (lmd_op_e'(operation_i) == OP_CLEAR)) ? 3'd0 : row_i;
      col_q  <= column_i;
      val_q  <= value_i;
      flag_q <= flag_i;
      rop_q  <= raw_opcode_i;
    end else if (cmd_i.frame_step) begin
      row_q <= row_q + 3'd1;
    end
    if (cmd_i.calc) begin
      word_q    <= 3'(chain_n - 4'd1);
      frm_opc_q <= frm_opc_d;
      frm_dat_q <= frm_dat_d;
    end else if (cmd_i.word_step) begin
      word_q <= word_q - 3'd1;
    end
  end

  // shadow entries read as zero until first written
  assign addr = AW'({dev_q[DEV_W-1:0], row_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rvld_q <= vld_q[addr];
    end
  end

  lmd_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_shadow (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(addr),
    .wdata_i(wr_data),
    .re_i   (cmd_i.rd),
    .raddr_i(addr),
    .rdata_o(rdata)
  );

  assign cur      = rvld_q ? rdata : 8'd0;
  assign mask     = 8'h80 >> col_q;
  assign bit_on   = (op_q == OP_COLUMN) ? val_q[3'd7 - row_q] : flag_q;
  assign led_byte = bit_on ? (cur | mask) : (cur & ~mask);
  assign row_opc  = {1'b0, row_q} + 4'd1;

  always_comb begin
    frm_opc_d = rop_q;
    frm_dat_d = val_q;
    wr_en     = 1'b0;
    wr_data   = val_q;
    case (op_q)
      OP_LED, OP_COLUMN: begin
        frm_opc_d = row_opc;
        frm_dat_d = led_byte;
        wr_en     = cmd_i.calc;
        wr_data   = led_byte;
      end
      OP_ROW: begin
        frm_opc_d = row_opc;
        wr_en     = cmd_i.calc;
      end
      OP_CLEAR: begin
        frm_opc_d = row_opc;
        frm_dat_d = 8'd0;
        wr_en     = cmd_i.calc;
        wr_data   = 8'd0;
      end
      OP_POWER: begin
        frm_opc_d = OPC_SHUTDOWN;
        frm_dat_d = flag_q ? 8'd0 : 8'd1;
      end
      OP_BRIGHTNESS: begin
        frm_opc_d = OPC_INTENSITY;
      end
      OP_SCAN_DIGITS: begin
        frm_opc_d = OPC_SCANLIMIT;
      end
      default: begin
        frm_opc_d = rop_q;
      end
    endcase
  end

  assign opcode_o       = ({1'b0, word_q} == dev_q) ? frm_opc_q : OPC_NOOP;
  assign data_o         = ({1'b0, word_q} == dev_q) ? frm_dat_q : 8'd0;
  assign end_of_frame_o = sts_o.word_zero;
  assign last_o         = sts_o.word_zero && sts_o.frames_done;

endmodule

`default_nettype wire

/* hdl/led_matrix_driver_chain_framer.sv */
// The first word follows the shadow read and frame build after a command is taken.
// Each frame is a shadow read, a frame build, then n words (n = chain length).
// No new command is taken until every word is sent; column and clear send 8 frames.
// A rejected command is taken but sends nothing; a stalled word is held.
// Reset: row shadow reads all zero (per-entry valid bits), chain length 8.
// ----------------------------------------------------------------------------
// led_matrix_driver_chain_framer
// Turns display commands into daisy-chain frames of 16-bit driver words.
// ----------------------------------------------------------------------------
`default_nettype none

module led_matrix_driver_chain_framer
  import lmd_pkg::*;
#(
  parameter int MAX_DEVICES = LMD_MAX_DEVICES
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_wr_en_i,
  input  wire logic [3:0] cfg_wr_data_i,
  lmd_in_if.sink          in_i,
  lmd_out_if.source       out_o
);

  lmd_cmd_t cmd;
  lmd_sts_t sts;

  lmd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lmd_dpath #(
    .MAX_DEVICES(MAX_DEVICES)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .operation_i   (in_i.operation),
    .device_i      (in_i.device),
    .row_i         (in_i.row),
    .column_i      (in_i.column),
    .value_i       (in_i.value),
    .flag_i        (in_i.flag),
    .raw_opcode_i  (in_i.raw_opcode),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_o      (out_o.opcode),
    .data_o        (out_o.data),
    .end_of_frame_o(out_o.end_of_frame),
    .last_o        (out_o.last)
  );

endmodule

`default_nettype wire

/* hdl/lmd_checker.sv */
// ----------------------------------------------------------------------------
// lmd_checker
// Port-level checks for the framer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lmd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [3:0] out_opcode_i,
  input wire logic [7:0] out_data_i,
  input wire logic       out_eof_i,
  input wire logic       out_last_i
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("command taken while words pending");

  a_taken_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !out_valid_i)
    else $error("word right after command taken");

  a_last_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_last_i) |-> out_eof_i)
    else $error("last word not at end of frame");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && out_last_i) |=> (!out_valid_i && in_ready_i))
    else $error("words after last word");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_opcode_i) && $stable(out_data_i) &&
       $stable(out_eof_i) && $stable(out_last_i)))
    else $error("stalled word changed");

endmodule

bind led_matrix_driver_chain_framer lmd_checker u_lmd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_opcode_i(out_o.opcode),
  .out_data_i  (out_o.data),
  .out_eof_i   (out_o.end_of_frame),
  .out_last_i  (out_o.last)
);

`default_nettype wire

/* dv/led_matrix_driver_chain_framer_test.sv */
// ----------------------------------------------------------------------------
// led_matrix_driver_chain_framer_test
// Self-checking bench for the chain framer. Display commands go in over the
// command channel and every chain word that comes out is checked against a
// model of the row shadow and the frame layout: directed cases per command
// first, then random traffic over several chain lengths, with random stalls on
// both channels for the first four lengths.
// ----------------------------------------------------------------------------
`default_nettype none

module led_matrix_driver_chain_framer_test;
  import lmd_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int ROWS_TOTAL   = LMD_MAX_DEVICES * 8;
  localparam int CHAIN_CAP    = (LMD_MAX_DEVICES < LMD_HARD_LIMIT) ?
                                LMD_MAX_DEVICES : LMD_HARD_LIMIT;

  typedef struct packed {
    lmd_op_e    op;
    logic [3:0] device;
    logic [2:0] row;
    logic [2:0] column;
    logic [7:0] value;
    logic       flag;
    logic [3:0] raw_opcode;
  } disp_cmd_t;

  typedef struct packed {
    logic [3:0] opcode;
    logic [7:0] data;
    logic       end_of_frame;
    logic       last;
  } chain_word_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_wr_en_i;
  logic [3:0] cfg_wr_data_i;

  lmd_in_if  cmd_if ();
  lmd_out_if word_if ();

  led_matrix_driver_chain_framer #(
    .MAX_DEVICES (LMD_MAX_DEVICES)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_i          (cmd_if),
    .out_o         (word_if)
  );

  chain_word_t chain_words[$];
  logic [7:0]  led_rows [ROWS_TOTAL];
  int          chain_len;
  int          src_idle;
  int          snk_idle;
  int          err_cnt;
  int          cmds_sent;
  int          words_checked;
  int          lengths_run;
  int          stall_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model
  function automatic void push_frame(int dev, logic [3:0] opc, logic [7:0] dat);
    chain_word_t w;
    for (int d = chain_len - 1; d >= 0; d--) begin
      w.opcode       = (d == dev) ? opc : OPC_NOOP;
      w.data         = (d == dev) ? dat : 8'h00;
      w.end_of_frame = (d == 0);
      w.last         = 1'b0;
      chain_words.push_back(w);
    end
  endfunction

  function automatic void set_led(int dev, logic [2:0] row, logic [2:0] col, logic on);
    int         idx;
    logic [7:0] mask;
    idx  = dev * 8 + row;
    mask = 8'h80 >> col;
    if (on) begin
      led_rows[idx] = led_rows[idx] | mask;
    end else begin
      led_rows[idx] = led_rows[idx] & ~mask;
    end
    push_frame(dev, {1'b0, row} + 4'd1, led_rows[idx]);
  endfunction

  function automatic void predict_words(disp_cmd_t c);
    int          dev;
    int          start;
    chain_word_t w;
    dev   = c.device;
    start = chain_words.size();
    if (dev >= chain_len) begin
      return;
    end
    case (c.op)
      OP_LED: begin
        set_led(dev, c.row, c.column, c.flag);
      end
      OP_ROW: begin
        led_rows[dev * 8 + c.row] = c.value;
        push_frame(dev, {1'b0, c.row} + 4'd1, c.value);
      end
      OP_COLUMN: begin
        for (int r = 0; r < 8; r++) begin
          set_led(dev, r[2:0], c.column, c.value[7 - r]);
        end
      end
      OP_CLEAR: begin
        for (int r = 0; r < 8; r++) begin
          led_rows[dev * 8 + r] = 8'h00;
          push_frame(dev, r[3:0] + 4'd1, 8'h00);
        end
      end
      OP_POWER: begin
        push_frame(dev, OPC_SHUTDOWN, c.flag ? 8'h00 : 8'h01);
      end
      OP_BRIGHTNESS: begin
        if (c.value < 16) begin
          push_frame(dev, OPC_INTENSITY, c.value);
        end
      end
      OP_SCAN_DIGITS: begin
        if (c.value < 8) begin
          push_frame(dev, OPC_SCANLIMIT, c.value);
        end
      end
      default: begin
        push_frame(dev, c.raw_opcode, c.value);
      end
    endcase
    if (chain_words.size() > start) begin
      w      = chain_words.pop_back();
      w.last = 1'b1;
      chain_words.push_back(w);
    end
  endfunction

  // ------------------------------------------------------------- checking
  always @(posedge clk_i) begin : check_words
    chain_word_t exp_w;
    if (rst_ni && word_if.valid && word_if.ready) begin
      if (chain_words.size() == 0) begin
        $error("unexpected word: opcode %0d data %0h", word_if.opcode, word_if.data);
        err_cnt++;
      end else begin
        exp_w = chain_words.pop_front();
        words_checked++;
        if (word_if.opcode !== exp_w.opcode) begin
          $error("opcode: expected %0d, actual %0d", exp_w.opcode, word_if.opcode);
          err_cnt++;
        end
        if (word_if.data !== exp_w.data) begin
          $error("data: expected %0h, actual %0h", exp_w.data, word_if.data);
          err_cnt++;
        end
        if (word_if.end_of_frame !== exp_w.end_of_frame) begin
          $error("end_of_frame: expected %0b, actual %0b",
                 exp_w.end_of_frame, word_if.end_of_frame);
          err_cnt++;
        end
        if (word_if.last !== exp_w.last) begin
          $error("last: expected %0b, actual %0b", exp_w.last, word_if.last);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    word_if.ready <= ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (word_if.valid && word_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // -------------------------------------------------------------- driving
  task automatic send_cmd(input disp_cmd_t c);
    while ($urandom_range(99) < src_idle) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.operation  <= c.op;
    cmd_if.device     <= c.device;
    cmd_if.row        <= c.row;
    cmd_if.column     <= c.column;
    cmd_if.value      <= c.value;
    cmd_if.flag       <= c.flag;
    cmd_if.raw_opcode <= c.raw_opcode;
    @(posedge clk_i);
    while (!cmd_if.ready) begin
      @(posedge clk_i);
    end
    predict_words(c);
    cmds_sent++;
  endtask

  task automatic drain_words();
    cmd_if.valid <= 1'b0;
    while (chain_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_chain_length(input logic [3:0] n);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= n;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    chain_len = (n == 0 || n > CHAIN_CAP) ? CHAIN_CAP : int'(n);
    lengths_run++;
  endtask

  function automatic disp_cmd_t mk_cmd(lmd_op_e op, logic [3:0] dev, logic [2:0] row,
                                       logic [2:0] col, logic [7:0] val, logic flag,
                                       logic [3:0] rop);
    disp_cmd_t c;
    c.op         = op;
    c.device     = dev;
    c.row        = row;
    c.column     = col;
    c.value      = val;
    c.flag       = flag;
    c.raw_opcode = rop;
    return c;
  endfunction

  function automatic disp_cmd_t random_cmd();
    disp_cmd_t c;
    c.op         = lmd_op_e'($urandom_range(7));
    c.device     = ($urandom_range(99) < 85) ? 4'($urandom_range(chain_len - 1)) :
                                               4'($urandom_range(15));
    c.row        = 3'($urandom_range(7));
    c.column     = 3'($urandom_range(7));
    c.value      = 8'($urandom_range(255));
    c.flag       = 1'($urandom_range(1));
    c.raw_opcode = 4'($urandom_range(15));
    if (c.op == OP_BRIGHTNESS && $urandom_range(99) < 80) begin
      c.value = 8'($urandom_range(15));
    end
    if (c.op == OP_SCAN_DIGITS && $urandom_range(99) < 80) begin
      c.value = 8'($urandom_range(7));
    end
    return c;
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_led();
    send_cmd(mk_cmd(OP_LED, 4'd0, 3'd0, 3'd0, 8'h00, 1'b1, 4'd0));
    send_cmd(mk_cmd(OP_LED, 4'd7, 3'd7, 3'd7, 8'hFF, 1'b1, 4'd15));
    send_cmd(mk_cmd(OP_LED, 4'd0, 3'd0, 3'd3, 8'h00, 1'b1, 4'd0));
    send_cmd(mk_cmd(OP_LED, 4'd0, 3'd0, 3'd0, 8'h00, 1'b0, 4'd0));
  endtask

  task automatic test_row();
    send_cmd(mk_cmd(OP_ROW, 4'd3, 3'd5, 3'd0, 8'hFF, 1'b0, 4'd0));
    send_cmd(mk_cmd(OP_ROW, 4'd7, 3'd0, 3'd7, 8'h00, 1'b1, 4'd15));
  endtask

  task automatic test_column();
    send_cmd(mk_cmd(OP_COLUMN, 4'd3, 3'd0, 3'd2, 8'hA5, 1'b0, 4'd0));
    send_cmd(mk_cmd(OP_COLUMN, 4'd0, 3'd7, 3'd7, 8'hFF, 1'b1, 4'd0));
  endtask

  task automatic test_clear();
    send_cmd(mk_cmd(OP_CLEAR, 4'd3, 3'd0, 3'd0, 8'h00, 1'b0, 4'd0));
    send_cmd(mk_cmd(OP_ROW, 4'd3, 3'd5, 3'd0, 8'h00, 1'b0, 4'd0));
  endtask

  task automatic test_shutdown();
    send_cmd(mk_cmd(OP_POWER, 4'd1, 3'd0, 3'd0, 8'h00, 1'b1, 4'd0));
    send_cmd(mk_cmd(OP_POWER, 4'd6, 3'd0, 3'd0, 8'hFF, 1'b0, 4'd0));
  endtask

  task automatic test_intensity();
    send_cmd(mk_cmd(OP_BRIGHTNESS, 4'd2, 3'd0, 3'd0, 8'd0, 1'b0, 4'd0));
    send_cmd(mk_cmd(OP_BRIGHTNESS, 4'd2, 3'd0, 3'd0, 8'd15, 1'b0, 4'd0));
    send_cmd(mk_cmd(OP_BRIGHTNESS, 4'd2, 3'd0, 3'd0, 8'd16, 1'b0, 4'd0));
    send_cmd(mk_cmd(OP_BRIGHTNESS, 4'd2, 3'd0, 3'd0, 8'd255, 1'b0, 4'd0));
  endtask

  task automatic test_scan_limit();
    send_cmd(mk_cmd(OP_SCAN_DIGITS, 4'd5, 3'd0, 3'd0, 8'd7, 1'b0, 4'd0));
    send_cmd(mk_cmd(OP_SCAN_DIGITS, 4'd5, 3'd0, 3'd0, 8'd8, 1'b0, 4'd0));
  endtask

  task automatic test_raw();
    send_cmd(mk_cmd(OP_RAW, 4'd4, 3'd0, 3'd0, 8'hFF, 1'b0, 4'd15));
    send_cmd(mk_cmd(OP_RAW, 4'd0, 3'd0, 3'd0, 8'h00, 1'b0, 4'd0));
  endtask

  task automatic test_bad_device();
    send_cmd(mk_cmd(OP_ROW, 4'd8, 3'd1, 3'd0, 8'h55, 1'b0, 4'd0));
    send_cmd(mk_cmd(OP_CLEAR, 4'd15, 3'd0, 3'd0, 8'h00, 1'b1, 4'd15));
  endtask

  task automatic test_random_traffic();
    logic [3:0] lengths [6];
    lengths = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5};
    for (int p = 0; p < 6; p++) begin
      drain_words();
      write_chain_length(lengths[p]);
      case (p / 2)
        0:       begin src_idle = 19; snk_idle = 76; end
        1:       begin src_idle = 76; snk_idle = 19; end
        default: begin src_idle = 0;  snk_idle = 0;  end
      endcase
      for (int i = 0; i < 43; i++) begin
        if (p == 2 && i == 23) begin
          drain_words();
        end
        send_cmd(random_cmd());
      end
    end
  endtask

  initial begin
    err_cnt       = 0;
    cmds_sent     = 0;
    words_checked = 0;
    lengths_run   = 0;
    chain_len     = CHAIN_CAP;
    src_idle      = 19;
    snk_idle      = 76;
    for (int i = 0; i < ROWS_TOTAL; i++) begin
      led_rows[i] = 8'h00;
    end
    rst_ni            <= 1'b0;
    cfg_wr_en_i       <= 1'b0;
    cfg_wr_data_i     <= 4'd0;
    cmd_if.valid      <= 1'b0;
    cmd_if.operation  <= OP_LED;
    cmd_if.device     <= 4'd0;
    cmd_if.row        <= 3'd0;
    cmd_if.column     <= 3'd0;
    cmd_if.value      <= 8'd0;
    cmd_if.flag       <= 1'b0;
    cmd_if.raw_opcode <= 4'd0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_led();
    test_row();
    test_column();
    test_clear();
    test_shutdown();
    test_intensity();
    test_scan_limit();
    test_raw();
    test_bad_device();
    test_random_traffic();

    drain_words();
    if (chain_words.size() != 0) begin
      $error("%0d expected words never arrived", chain_words.size());
      err_cnt++;
    end
    $display("%0d commands over %0d chain length settings, %0d chain words checked",
             cmds_sent, lengths_run, words_checked);
    $display("all eight commands, bad device and value rejects, lengths 1/3/5/8 and 0/15");
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
